// File: rtl/tss_pkg.sv
// package for the tone song sequencer
// holds opcodes, register indexes, field widths and the item, result, config and state types
// no dependencies
package tss_pkg;

    localparam int TONE_W = 16;
    localparam int SLOT_W = 8;
    localparam int LEN_W  = 8;
    localparam int NOTE_W = LEN_W + TONE_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_START_TONE = 3'd1,
        OP_STOP_TONE  = 3'd2,
        OP_START_SONG = 3'd3,
        OP_STOP_SONG  = 3'd4,
        OP_LOAD_NOTE  = 3'd5
    } tss_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_SONG_TEMPO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SONG_REPEAT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TONE  = 8'd3;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [TONE_W-1:0] tone_period;
        logic [SLOT_W-1:0] note_slot;
        logic [LEN_W-1:0]  note_length;
    } tss_item_t;

    typedef struct packed {
        logic [TONE_W-1:0] period_out;
        logic              generator_on;
        logic              restart_count;
        logic              song_active;
        logic              beep_active;
    } tss_result_t;

    typedef struct packed {
        logic [7:0]        song_tempo;
        logic [7:0]        song_length;
        logic              song_repeat;
        logic [TONE_W-1:0] pause_tone;
    } tss_cfg_t;

    typedef struct packed {
        logic              song_flag;
        logic              beep_flag;
        logic [7:0]        note_pointer;
        logic [7:0]        tempo_countdown;
        logic [LEN_W-1:0]  note_countdown;
        logic [TONE_W-1:0] period;
        logic              running;
    } tss_state_t;

endpackage

// File: rtl/tone_song_sequencer.sv
// Tone and song sequencer for a PWM tone generator.
// Items enter on the s_ group: s_tuser carries the opcode (tick, start tone, stop tone,
// start song, stop song, load note), s_tdata the tone period, note slot and note length.
// Every item gives exactly one result on the m_ group: the generator period, whether the
// generator runs, whether its counter restarts, and the song and beep flags after the item.
// Configuration (tempo, song length, repeat, pause tone) is written on the cfg_ channel,
// which is always ready; it is meant to be written while no item is in flight.
// An accepted item passes through the input register and then the result register to m_tvalid.
// Throughput is one item per cycle while m_tready stays high; the note store's registered read port is fed the
// pointer left by the previous item, so a tick can fetch a note without waiting on the store.
// When m_tready is low the result register holds, the input register still takes an item
// if it is empty, and s_tready then stays low until the result is taken.
// Reset clears the configuration, all flags, countdowns, pointer and the generator
// settings; the note store is not cleared and holds no valid notes until loaded.
// Uses tss_pkg, tss_core and tss_note_mem.
module tone_song_sequencer
    import tss_pkg::*;
#(
    parameter int MAX_NOTES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] tone_period, [23:16] note_slot, [31:24] note_length
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [2:0] opcode
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] period_out, [16] generator_on, [17] restart_count,
    // [18] song_active, [19] beep_active, [23:20] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_NOTES);

    tss_item_t   in_reg;
    logic        in_valid_reg;
    tss_result_t out_reg;
    logic        out_valid_reg;
    tss_cfg_t    cfg_reg;
    tss_result_t result;
    logic        advance;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [NOTE_W-1:0] wr_data;
    logic [NOTE_W-1:0] rd_data;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.opcode      <= s_tuser;
            in_reg.tone_period <= s_tdata[15:0];
            in_reg.note_slot   <= s_tdata[23:16];
            in_reg.note_length <= s_tdata[31:24];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SONG_TEMPO:  cfg_reg.song_tempo  <= cfg_data[7:0];
                REG_SONG_LENGTH: cfg_reg.song_length <= cfg_data[7:0];
                REG_SONG_REPEAT: cfg_reg.song_repeat <= cfg_data[0];
                REG_PAUSE_TONE:  cfg_reg.pause_tone  <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    tss_core #(
        .MAX_NOTES (MAX_NOTES),
        .ADDR_W    (ADDR_W)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .result  (result)
    );

    tss_note_mem #(
        .DEPTH  (MAX_NOTES),
        .ADDR_W (ADDR_W),
        .DATA_W (NOTE_W)
    ) u_note_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.beep_active, out_reg.song_active,
                       out_reg.restart_count, out_reg.generator_on, out_reg.period_out};

endmodule

// File: rtl/tss_note_mem.sv
// note store: one write port, one registered read port, write-first on a same-address access
// no package dependencies
module tss_note_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tss_core.sv
// sequencer state and the per-item update of flags, countdowns, pointer and generator settings
// uses tss_pkg; the note store read data comes in already registered for the current pointer
module tss_core
    import tss_pkg::*;
#(
    parameter int MAX_NOTES = 256,
    parameter int ADDR_W    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tss_item_t         item,
    input  tss_cfg_t          cfg,
    input  logic [NOTE_W-1:0] rd_data,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [NOTE_W-1:0] wr_data,
    output tss_result_t       result
);

    // wide enough to hold MAX_NOTES itself and any 8-bit index
    localparam int PW = ((ADDR_W + 1) > 8) ? (ADDR_W + 1) : 8;

    tss_state_t state_reg;
    tss_state_t state_next;
    logic       oob_reg;
    logic       oob_next;
    logic       restart;
    logic [NOTE_W-1:0] note;
    logic [7:0] ptr_inc;
    logic [PW-1:0] ptr_wide;
    logic [PW-1:0] slot_wide;

    // current note, reads as zero past the end of the store
    assign note = oob_reg ? '0 : rd_data;
    assign ptr_inc = state_reg.note_pointer + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        restart    = 1'b0;
        if (fire)
        begin
            case (tss_op_t'(item.opcode))
                OP_TICK:
                begin
                    if (!state_reg.beep_flag && state_reg.song_flag)
                    begin
                        if (state_reg.tempo_countdown != 8'd0)
                        begin
                            state_next.tempo_countdown = state_reg.tempo_countdown - 8'd1;
                        end
                        else
                        begin
                            if (state_reg.note_countdown != '0)
                            begin
                                state_next.note_countdown = state_reg.note_countdown - LEN_W'(1);
                            end
                            else if (state_reg.note_pointer < cfg.song_length)
                            begin
                                state_next.note_countdown = note[NOTE_W-1:TONE_W];
                                state_next.period         = note[TONE_W-1:0];
                                state_next.running        = (note[TONE_W-1:0] != cfg.pause_tone);
                                restart                   = 1'b1;
                                if ((ptr_inc == cfg.song_length) && cfg.song_repeat)
                                begin
                                    state_next.note_pointer = 8'd0;
                                end
                                else
                                begin
                                    state_next.note_pointer = ptr_inc;
                                end
                            end
                            else
                            begin
                                state_next.song_flag = 1'b0;
                                state_next.running   = 1'b0;
                            end
                            state_next.tempo_countdown = cfg.song_tempo;
                        end
                    end
                end
                OP_START_TONE:
                begin
                    if (!state_reg.song_flag)
                    begin
                        state_next.period    = item.tone_period;
                        state_next.running   = 1'b1;
                        state_next.beep_flag = 1'b1;
                        restart              = 1'b1;
                    end
                end
                OP_STOP_TONE:
                begin
                    state_next.beep_flag = 1'b0;
                    if (!state_reg.song_flag)
                    begin
                        state_next.running = 1'b0;
                    end
                end
                OP_START_SONG:
                begin
                    state_next.note_pointer    = 8'd0;
                    state_next.note_countdown  = '0;
                    state_next.tempo_countdown = cfg.song_tempo;
                    state_next.song_flag       = 1'b1;
                    state_next.running         = 1'b1;
                end
                OP_STOP_SONG:
                begin
                    state_next.song_flag = 1'b0;
                    if (!state_reg.beep_flag)
                    begin
                        state_next.running = 1'b0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // prefetch the note at the pointer the next item will see
    assign ptr_wide  = PW'(state_next.note_pointer);
    assign rd_addr   = ptr_wide[ADDR_W-1:0];
    assign oob_next  = (ptr_wide >= PW'(MAX_NOTES));

    assign slot_wide = PW'(item.note_slot);
    assign wr_en     = fire && (tss_op_t'(item.opcode) == OP_LOAD_NOTE)
                       && (slot_wide < PW'(MAX_NOTES));
    assign wr_addr   = slot_wide[ADDR_W-1:0];
    assign wr_data   = {item.note_length, item.tone_period};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            oob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oob_reg   <= oob_next;
        end
    end

    assign result.period_out    = state_next.period;
    assign result.generator_on  = state_next.running;
    assign result.restart_count = restart;
    assign result.song_active   = state_next.song_flag;
    assign result.beep_active   = state_next.beep_flag;

endmodule
